/* rtl/core/spp_pkg.sv */
// ----------------------------------------------------------------------------
// Surface point projection package
// Shared widths, register codes, datapath commands and helper functions.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int COORD_W  = 24;   // signed Q8.16 coordinate
    localparam int RAD_W    = 23;   // unsigned Q7.16 radius and half length
    localparam int STR_W    = 15;   // unsigned Q3.12 stretch
    localparam int SHAPE_W  = 2;
    localparam int STAT_W   = 2;
    localparam int P_W      = 27;   // ellipsoid iterate, bounded to +-2^25
    localparam int V_W      = 29;   // length vector and step vector elements
    localparam int N_W      = 29;   // scaled surface coordinates
    localparam int M_W      = 30;   // multiplier operand width
    localparam int PROD_W   = 60;   // multiplier product width
    localparam int ACC_W    = 60;   // sum of squares
    localparam int RADICAND_W = 64;
    localparam int ROOT_W   = 32;
    localparam int NUM_W    = 56;   // divider numerator magnitude
    localparam int DEN_W    = 32;
    localparam int QUO_W    = 32;
    localparam int Q_W      = 34;   // signed rounded quotient
    localparam int SS_W     = 29;   // stretch squared
    localparam int SAT_W    = 36;   // width used ahead of output saturation
    localparam int GUARD    = 2;
    localparam int STR_SH   = 12;   // stretch of one is 2^12
    localparam int E2_SH    = 24;   // stretch squared of one is 2^24
    localparam int CONV_W   = 39;

    localparam logic [STR_W-1:0] STRETCH_MIN = 15'd1024;
    localparam logic [STR_W-1:0] STRETCH_MAX = 15'd16384;
    localparam logic [6:0]       CONV_MUL    = 7'd125;

    localparam logic signed [Q_W:0] ITER_HI = 35'sd33554432;
    localparam logic signed [Q_W:0] ITER_LO = -35'sd33554432;
    localparam logic signed [SAT_W-1:0] OUT_HI = 36'sd8388607;
    localparam logic signed [SAT_W-1:0] OUT_LO = -36'sd8388608;

    // Body shape codes.
    localparam logic [SHAPE_W-1:0] SHAPE_SPHERE    = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_ELLIPSOID = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_CAPSULE   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DEGEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SHAPE   = 2'd0;
    localparam logic [1:0] REG_RADIUS  = 2'd1;
    localparam logic [1:0] REG_HALFLEN = 2'd2;
    localparam logic [1:0] REG_STRETCH = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SS,
        OP_VEC_P,
        OP_VEC_CYL,
        OP_VEC_CAP,
        OP_VEC_QZ,
        OP_VEC_E,
        OP_SQ,
        OP_SQRT,
        OP_MUL_SC,
        OP_DIV_SC,
        OP_DIV_QZ,
        OP_DIV_E2,
        OP_STORE_N,
        OP_MUL_N2,
        OP_RND_N2,
        OP_E_CALC,
        OP_UPDATE,
        OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        OUT_ORIG,
        OUT_SPH,
        OUT_CYL,
        OUT_CAP,
        OUT_ITER
    } out_sel_t;

    typedef struct packed {
        dp_op_t            op;
        logic [1:0]        idx;
        out_sel_t          out_sel;
        logic [STAT_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic l_zero;
        logic converged;
        logic in_band;
        logic r_zero;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SS,
        S_QZ_DIV,
        S_QZ_WAIT,
        S_VEC_QZ,
        S_SQ,
        S_SQRT,
        S_SQRT_WAIT,
        S_LCHK,
        S_SC_MUL,
        S_SC_DIV,
        S_SC_WAIT,
        S_SC_STORE,
        S_N2_MUL,
        S_N2_RND,
        S_E_CALC,
        S_VEC_E,
        S_E2_DIV,
        S_E2_WAIT,
        S_UPDATE,
        S_OUT
    } ctrl_state_t;

    // Saturate a wide signed value onto the 24 bit coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAT_W-1:0] t;
        begin
            t = v;
            if (v > OUT_HI) t = OUT_HI;
            if (v < OUT_LO) t = OUT_LO;
            sat_coord = t[COORD_W-1:0];
        end
    endfunction

    // Bound an ellipsoid iterate coordinate to +-2^25.
    function automatic logic signed [P_W-1:0] clamp_iter(
        input logic signed [Q_W:0] v
    );
        logic signed [Q_W:0] t;
        begin
            t = v;
            if (v > ITER_HI) t = ITER_HI;
            if (v < ITER_LO) t = ITER_LO;
            clamp_iter = t[P_W-1:0];
        end
    endfunction

endpackage

/* rtl/core/spp_sqrt.sv */
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64 bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module spp_sqrt import spp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [RADICAND_W-1:0] radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    logic [RADICAND_W-1:0] v_reg, r_reg, bit_reg;
    logic [RADICAND_W-1:0] v_next, r_next, trial;
    logic                  busy_reg, done_reg;

    assign trial = r_reg + bit_reg;

    always_comb begin
        if (v_reg >= trial) begin
            v_next = v_reg - trial;
            r_next = (r_reg >> 1) + bit_reg;
        end else begin
            v_next = v_reg;
            r_next = r_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= RADICAND_W'(1) << (RADICAND_W - 2);
        end else if (busy_reg) begin
            v_reg   <= v_next;
            r_reg   <= r_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

/* rtl/core/spp_div.sv */
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, 32 quotient bits.
// ----------------------------------------------------------------------------
module spp_div import spp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [QUO_W-1:0] sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    // The caller guarantees the quotient fits, so the top bits start below den.
    assign trial = {rem_reg, sh_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num[NUM_W-1:QUO_W]);
            sh_reg  <= num[QUO_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_reg  <= {sh_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

/* rtl/core/spp_dp.sv */
// ----------------------------------------------------------------------------
// Surface point projection datapath
// Operand registers, shared multiplier, square root and divider units.
// ----------------------------------------------------------------------------
module spp_dp import spp_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    input  logic signed [COORD_W-1:0]   in_x,
    input  logic signed [COORD_W-1:0]   in_y,
    input  logic signed [COORD_W-1:0]   in_z,
    input  logic [RAD_W-1:0]            radius,
    input  logic [RAD_W-1:0]            half_len,
    input  logic [STR_W-1:0]            stretch,
    output logic signed [COORD_W-1:0]   res_x,
    output logic signed [COORD_W-1:0]   res_y,
    output logic signed [COORD_W-1:0]   res_z,
    output logic [STAT_W-1:0]           res_status
);

    logic signed [COORD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [P_W-1:0]     px_reg, py_reg, pz_reg;
    logic [STR_W-1:0]          s_reg;
    logic [SS_W-1:0]           ss_reg;
    logic signed [V_W-1:0]     va_reg, vb_reg, vc_reg;
    logic signed [V_W-1:0]     e0_reg, e1_reg, e2_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [ROOT_W-1:0]         l_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [N_W-1:0]     n0_reg, n1_reg, n2_reg;
    logic signed [Q_W-1:0]     q_reg;
    logic                      q_neg_reg;
    logic signed [COORD_W-1:0] rx_reg, ry_reg, rz_reg;
    logic [STAT_W-1:0]         rs_reg;

    logic signed [V_W-1:0]     vsel;
    logic signed [M_W-1:0]     vsel_ext, vmag, mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         prod_mag, n2_rnd;
    logic signed [N_W-1:0]     n2_round;
    logic [P_W:0]              pz_ext, pz_mag;
    logic [M_W-1:0]            e2_ext, e2_mag;
    logic [STR_W-1:0]          s_sat;
    logic                      div_start, div_done, sqrt_done, div_neg;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [QUO_W-1:0]          quo;
    logic [ROOT_W-1:0]         root;
    logic signed [V_W-1:0]     cap_z;
    logic [COORD_W:0]          oz_ext, oz_mag;
    logic signed [SAT_W-1:0]   cap_out;

    // Element picked by the command index.
    always_comb begin
        case (cmd.idx)
            2'd0:    vsel = va_reg;
            2'd1:    vsel = vb_reg;
            default: vsel = vc_reg;
        endcase
        vsel_ext = M_W'(vsel);
        vmag     = vsel_ext[M_W-1] ? -vsel_ext : vsel_ext;
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ: begin
                mul_a = vmag;
                mul_b = vmag;
            end
            OP_MUL_SC: begin
                mul_a = vsel_ext;
                mul_b = $signed({5'b0, radius, 2'b00});
            end
            OP_MUL_N2: begin
                mul_a = M_W'(n2_reg);
                mul_b = $signed({15'b0, s_reg});
            end
            OP_SS: begin
                mul_a = $signed({15'b0, s_reg});
                mul_b = $signed({15'b0, s_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        if (stretch < STRETCH_MIN)      s_sat = STRETCH_MIN;
        else if (stretch > STRETCH_MAX) s_sat = STRETCH_MAX;
        else                            s_sat = stretch;
    end

    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign n2_rnd   = (prod_mag + PROD_W'(1 << (STR_SH - 1))) >> STR_SH;

    always_comb begin
        n2_round = N_W'(n2_rnd);
        if (prod_reg[PROD_W-1]) n2_round = -n2_round;
    end

    assign pz_ext = (P_W+1)'(pz_reg);
    assign pz_mag = pz_ext[P_W] ? -pz_ext : pz_ext;
    assign e2_ext = M_W'(e2_reg);
    assign e2_mag = e2_ext[M_W-1] ? -e2_ext : e2_ext;

    // Divider operands: magnitude plus half the divisor rounds to nearest.
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;
        case (cmd.op)
            OP_DIV_SC: begin
                div_start = 1'b1;
                div_num   = prod_mag[NUM_W-1:0] + NUM_W'(l_reg >> 1);
                div_den   = l_reg;
                div_neg   = prod_reg[PROD_W-1];
            end
            OP_DIV_QZ: begin
                div_start = 1'b1;
                div_num   = NUM_W'({pz_mag, {STR_SH{1'b0}}}) + NUM_W'(s_reg >> 1);
                div_den   = DEN_W'(s_reg);
                div_neg   = pz_reg[P_W-1];
            end
            OP_DIV_E2: begin
                div_start = 1'b1;
                div_num   = NUM_W'({e2_mag, {E2_SH{1'b0}}}) + NUM_W'(ss_reg >> 1);
                div_den   = DEN_W'(ss_reg);
                div_neg   = e2_reg[V_W-1];
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    spp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_SQRT),
        .radicand ({acc_reg, {(2*GUARD){1'b0}}}),
        .done     (sqrt_done),
        .root     (root)
    );

    spp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    assign cap_z  = pz_reg[P_W-1] ? V_W'(pz_reg) + V_W'(half_len)
                                  : V_W'(pz_reg) - V_W'(half_len);
    assign cap_out = oz_reg[COORD_W-1] ? SAT_W'(n2_reg) - SAT_W'(half_len)
                                       : SAT_W'(n2_reg) + SAT_W'(half_len);

    always_ff @(posedge aclk) begin
        if (sqrt_done) l_reg <= root;
        if (div_done) begin
            q_reg <= q_neg_reg ? -Q_W'(quo) : Q_W'(quo);
        end
        if (div_start) q_neg_reg <= div_neg;
        case (cmd.op) inside
            OP_LOAD: begin
                ox_reg <= in_x;
                oy_reg <= in_y;
                oz_reg <= in_z;
                px_reg <= P_W'(in_x);
                py_reg <= P_W'(in_y);
                pz_reg <= P_W'(in_z);
                s_reg  <= s_sat;
            end
            OP_SS: ss_reg <= prod[SS_W-1:0];
            OP_VEC_P: begin
                va_reg <= V_W'(px_reg);
                vb_reg <= V_W'(py_reg);
                vc_reg <= V_W'(pz_reg);
            end
            OP_VEC_CYL: begin
                va_reg <= V_W'(px_reg);
                vb_reg <= V_W'(py_reg);
                vc_reg <= '0;
            end
            OP_VEC_CAP: begin
                va_reg <= V_W'(px_reg);
                vb_reg <= V_W'(py_reg);
                vc_reg <= cap_z;
            end
            OP_VEC_QZ: begin
                va_reg <= V_W'(px_reg);
                vb_reg <= V_W'(py_reg);
                vc_reg <= q_reg[V_W-1:0];
            end
            OP_VEC_E: begin
                va_reg <= e0_reg;
                vb_reg <= e1_reg;
                vc_reg <= e2_reg;
            end
            OP_SQ: begin
                acc_reg <= ((cmd.idx == 2'd0) ? '0 : acc_reg) + ACC_W'(prod);
            end
            OP_MUL_SC, OP_MUL_N2: prod_reg <= prod;
            OP_STORE_N: begin
                case (cmd.idx)
                    2'd0:    n0_reg <= q_reg[N_W-1:0];
                    2'd1:    n1_reg <= q_reg[N_W-1:0];
                    default: n2_reg <= q_reg[N_W-1:0];
                endcase
            end
            OP_RND_N2: n2_reg <= n2_round;
            OP_E_CALC: begin
                e0_reg <= V_W'(n0_reg) - V_W'(px_reg);
                e1_reg <= V_W'(n1_reg) - V_W'(py_reg);
                e2_reg <= V_W'(n2_reg) - V_W'(pz_reg);
            end
            OP_UPDATE: begin
                px_reg <= clamp_iter((Q_W+1)'(px_reg) + (Q_W+1)'(e0_reg));
                py_reg <= clamp_iter((Q_W+1)'(py_reg) + (Q_W+1)'(e1_reg));
                pz_reg <= clamp_iter((Q_W+1)'(pz_reg) + (Q_W+1)'(q_reg));
            end
            OP_OUT: begin
                rs_reg <= cmd.status;
                case (cmd.out_sel)
                    OUT_SPH: begin
                        rx_reg <= sat_coord(SAT_W'(n0_reg));
                        ry_reg <= sat_coord(SAT_W'(n1_reg));
                        rz_reg <= sat_coord(SAT_W'(n2_reg));
                    end
                    OUT_CYL: begin
                        rx_reg <= sat_coord(SAT_W'(n0_reg));
                        ry_reg <= sat_coord(SAT_W'(n1_reg));
                        rz_reg <= oz_reg;
                    end
                    OUT_CAP: begin
                        rx_reg <= sat_coord(SAT_W'(n0_reg));
                        ry_reg <= sat_coord(SAT_W'(n1_reg));
                        rz_reg <= sat_coord(cap_out);
                    end
                    OUT_ITER: begin
                        rx_reg <= sat_coord(SAT_W'(px_reg));
                        ry_reg <= sat_coord(SAT_W'(py_reg));
                        rz_reg <= sat_coord(SAT_W'(pz_reg));
                    end
                    default: begin
                        rx_reg <= ox_reg;
                        ry_reg <= oy_reg;
                        rz_reg <= oz_reg;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign oz_ext = (COORD_W+1)'(oz_reg);
    assign oz_mag = oz_ext[COORD_W] ? -oz_ext : oz_ext;

    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;
    assign stat.l_zero    = (l_reg == '0);
    assign stat.converged = (CONV_W'(l_reg) * CONV_W'(CONV_MUL)) <= CONV_W'(radius);
    assign stat.in_band   = oz_mag < (COORD_W+1)'(half_len);
    assign stat.r_zero    = (radius == '0);

    assign res_x      = rx_reg;
    assign res_y      = ry_reg;
    assign res_z      = rz_reg;
    assign res_status = rs_reg;

endmodule

/* rtl/core/spp_ctrl.sv */
// ----------------------------------------------------------------------------
// Surface point projection controller
// Sequences datapath commands for each shape and owns both handshakes.
// ----------------------------------------------------------------------------
module spp_ctrl import spp_pkg::*; #(
    parameter int MAX_ITERATIONS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic [SHAPE_W-1:0] shape,
    input  dp_stat_t           stat,
    output dp_cmd_t            cmd
);

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    ctrl_state_t       state_reg, state_next;
    logic [1:0]        idx_reg, idx_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              step_len_reg, step_len_next;
    out_sel_t          out_sel_reg, out_sel_next;
    logic [STAT_W-1:0] ostat_reg, ostat_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            iter_reg     <= '0;
            step_len_reg <= 1'b0;
            out_sel_reg  <= OUT_ORIG;
            ostat_reg    <= ST_OK;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            iter_reg     <= iter_next;
            step_len_reg <= step_len_next;
            out_sel_reg  <= out_sel_next;
            ostat_reg    <= ostat_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        iter_next     = iter_reg;
        step_len_next = step_len_reg;
        out_sel_next  = out_sel_reg;
        ostat_next    = ostat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = 1'b0;
        cmd.op        = OP_NONE;
        cmd.idx       = idx_reg;
        cmd.out_sel   = out_sel_reg;
        cmd.status    = ostat_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                idx_next      = '0;
                step_len_next = 1'b0;
                iter_next     = '0;
                case (shape)
                    SHAPE_SPHERE: begin
                        cmd.op       = OP_VEC_P;
                        out_sel_next = OUT_SPH;
                        state_next   = S_SQ;
                    end
                    SHAPE_CAPSULE: begin
                        cmd.op       = stat.in_band ? OP_VEC_CYL : OP_VEC_CAP;
                        out_sel_next = stat.in_band ? OUT_CYL : OUT_CAP;
                        state_next   = S_SQ;
                    end
                    SHAPE_ELLIPSOID: begin
                        if (stat.r_zero) begin
                            out_sel_next = OUT_ORIG;
                            ostat_next   = ST_OK;
                            state_next   = S_OUT;
                        end else begin
                            out_sel_next = OUT_ITER;
                            state_next   = S_SS;
                        end
                    end
                    default: begin
                        out_sel_next = OUT_ORIG;
                        ostat_next   = ST_DEGEN;
                        state_next   = S_OUT;
                    end
                endcase
            end
            S_SS: begin
                cmd.op     = OP_SS;
                state_next = S_QZ_DIV;
            end
            S_QZ_DIV: begin
                cmd.op     = OP_DIV_QZ;
                state_next = S_QZ_WAIT;
            end
            S_QZ_WAIT: begin
                if (stat.div_done) state_next = S_VEC_QZ;
            end
            S_VEC_QZ: begin
                cmd.op        = OP_VEC_QZ;
                idx_next      = '0;
                step_len_next = 1'b0;
                state_next    = S_SQ;
            end
            S_SQ: begin
                cmd.op = OP_SQ;
                if (idx_reg == 2'd2) begin
                    idx_next   = '0;
                    state_next = S_SQRT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SQRT: begin
                cmd.op     = OP_SQRT;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (stat.sqrt_done) state_next = S_LCHK;
            end
            S_LCHK: begin
                idx_next = '0;
                if (step_len_reg) begin
                    state_next = S_E2_DIV;
                end else if (stat.l_zero) begin
                    out_sel_next = OUT_ORIG;
                    ostat_next   = ST_DEGEN;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_SC_MUL;
                end
            end
            S_SC_MUL: begin
                cmd.op     = OP_MUL_SC;
                state_next = S_SC_DIV;
            end
            S_SC_DIV: begin
                cmd.op     = OP_DIV_SC;
                state_next = S_SC_WAIT;
            end
            S_SC_WAIT: begin
                if (stat.div_done) state_next = S_SC_STORE;
            end
            S_SC_STORE: begin
                cmd.op = OP_STORE_N;
                // The cylinder band keeps z, so only x and y are scaled there.
                if ((idx_reg == 2'd2) || (idx_reg == 2'd1 && out_sel_reg == OUT_CYL)) begin
                    idx_next = '0;
                    if (out_sel_reg == OUT_ITER) begin
                        state_next = S_N2_MUL;
                    end else begin
                        ostat_next = ST_OK;
                        state_next = S_OUT;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SC_MUL;
                end
            end
            S_N2_MUL: begin
                cmd.op     = OP_MUL_N2;
                state_next = S_N2_RND;
            end
            S_N2_RND: begin
                cmd.op     = OP_RND_N2;
                state_next = S_E_CALC;
            end
            S_E_CALC: begin
                cmd.op     = OP_E_CALC;
                state_next = S_VEC_E;
            end
            S_VEC_E: begin
                cmd.op        = OP_VEC_E;
                idx_next      = '0;
                step_len_next = 1'b1;
                state_next    = S_SQ;
            end
            S_E2_DIV: begin
                cmd.op     = OP_DIV_E2;
                state_next = S_E2_WAIT;
            end
            S_E2_WAIT: begin
                if (stat.div_done) state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.op = OP_UPDATE;
                if (stat.converged) begin
                    ostat_next = ST_OK;
                    state_next = S_OUT;
                end else if (iter_reg == ITER_W'(MAX_ITERATIONS - 1)) begin
                    ostat_next = ST_LIMIT;
                    state_next = S_OUT;
                end else begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_QZ_DIV;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/core/surface_point_projection_core.sv */
// ----------------------------------------------------------------------------
// Surface point projection core
// Projects a 3D point onto a sphere, capsule or ellipsoid surface.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Payload
//  s_        in         s_valid/s_ready  s_point_x, s_point_y, s_point_z
//  m_        out        m_valid/m_ready  m_surface_x/y/z, m_status
//  APB       in         psel/penable     shape, radius, half length, stretch
//
//  The 32-step divider and square root unit, shared by every length and
//  scaling, set how long a sphere, capsule or ellipsoid item takes.
//  One item is in work at a time; a finished result waits in the output
//  register while the next input transfer is taken and processed.
//  Reset is synchronous and active low; it loads the register defaults.
//  A stalled result only holds the controller at its final write.
//
module surface_point_projection_core import spp_pkg::*; #(
    parameter int MAX_ITERATIONS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input point channel.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic signed [COORD_W-1:0] s_point_z,
    // Result channel.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_surface_x,
    output logic signed [COORD_W-1:0] m_surface_y,
    output logic signed [COORD_W-1:0] m_surface_z,
    output logic [STAT_W-1:0]         m_status,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [SHAPE_W-1:0] shape_select_reg;
    logic [RAD_W-1:0]   surface_radius_reg;
    logic [RAD_W-1:0]   half_length_reg;
    logic [STR_W-1:0]   stretch_factor_reg;
    logic               cfg_write;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    // Registers sit at byte addresses 0, 4, 8 and 12; a write completes in
    // the access phase since the port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_select_reg   <= SHAPE_SPHERE;
            surface_radius_reg <= 23'd65536;
            half_length_reg    <= '0;
            stretch_factor_reg <= 15'd4096;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_SHAPE:   shape_select_reg   <= pwdata[SHAPE_W-1:0];
                REG_RADIUS:  surface_radius_reg <= pwdata[RAD_W-1:0];
                REG_HALFLEN: half_length_reg    <= pwdata[RAD_W-1:0];
                REG_STRETCH: stretch_factor_reg <= pwdata[STR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SHAPE:   prdata = 32'(shape_select_reg);
            REG_RADIUS:  prdata = 32'(surface_radius_reg);
            REG_HALFLEN: prdata = 32'(half_length_reg);
            REG_STRETCH: prdata = 32'(stretch_factor_reg);
            default:     prdata = '0;
        endcase
    end

    // The controller walks each shape's sequence and the datapath carries
    // out one command per cycle, waiting on the shared iterative units and on a free output register.
    spp_ctrl #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .shape   (shape_select_reg),
        .stat    (stat),
        .cmd     (cmd)
    );

    spp_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_x       (s_point_x),
        .in_y       (s_point_y),
        .in_z       (s_point_z),
        .radius     (surface_radius_reg),
        .half_len   (half_length_reg),
        .stretch    (stretch_factor_reg),
        .res_x      (m_surface_x),
        .res_y      (m_surface_y),
        .res_z      (m_surface_z),
        .res_status (m_status)
    );

    // One item is in work at a time, so input is refused right after a transfer.
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_DEGEN || m_status == ST_LIMIT))
        else $error("result carries an unused status code");

    // Only the ellipsoid iterates, so no other shape can report the limit.
    a_limit_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && shape_select_reg != SHAPE_ELLIPSOID |-> m_status != ST_LIMIT)
        else $error("iteration limit reported for a non-iterating shape");

endmodule
